// ----- rtl/ofs_pkg.sv -----
// ofs_pkg: shared types, constants and a helper function of the overlapping frame segmenter
// used by ofs_ctrl, ofs_dpath and overlapping_frame_segmenter; no dependencies
package ofs_pkg;

    localparam int MAX_FRAME_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int FS_W    = 7;
    localparam int OV_W    = 11;
    localparam int UNTIL_W = 11;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 1;

    localparam logic [FS_W-1:0] FS_RESET = 7'd64;
    localparam logic [OV_W-1:0] OV_RESET = 11'd0;

    localparam logic [IDX_W-1:0] CFG_FRAME_SIZE = 1'b0;
    localparam logic [IDX_W-1:0] CFG_OVERLAP    = 1'b1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_ofs_state;

    typedef struct packed {
        logic write;
        logic flush;
        logic start;
        logic issue;
    } t_ofs_cmd;

    typedef struct packed {
        logic frame_due;
        logic out_free;
        logic last_rd;
    } t_ofs_sts;

    function automatic logic [FS_W-1:0] eff_fs(input logic [FS_W-1:0] fs, input int max_frame);
        logic [FS_W-1:0] res;
        res = fs;
        if (fs == '0) begin
            res = FS_W'(1);
        end else if (int'(fs) > max_frame) begin
            res = FS_W'(max_frame);
        end
        return res;
    endfunction

endpackage

// ----- rtl/overlapping_frame_segmenter.sv -----
// overlapping_frame_segmenter: top level, cuts a sample stream into overlapping frames
// depends on ofs_pkg, ofs_ctrl, ofs_dpath and ofs_ram
//
//   channel   valid        stall         payload
//   input     i_in_valid   o_in_stall    i_mode, i_sample
//   output    o_out_valid  i_out_stall   o_sample_out, o_frame_last
//   config    i_cfg_we     -             i_cfg_index, i_cfg_wdata
//
// a sample or flush beat is taken while o_in_stall is low; back-to-back beats are taken every cycle while it stays low
// a beat that completes a frame is followed by reads of its effective frame_size samples from the ring RAM
// (one beat per cycle without output stall), during which the input is stalled
// an output stall holds the RAM read register, which doubles as the output beat register
// synchronous active-low reset; the ring needs no clearing pass
module overlapping_frame_segmenter #(
    parameter int MAX_FRAME   = ofs_pkg::MAX_FRAME_DEF,
    parameter int SAMPLE_BITS = ofs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_mode,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [SAMPLE_BITS-1:0]    o_sample_out,
    output logic                      o_frame_last,
    input  logic                      i_cfg_we,
    input  logic [ofs_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [ofs_pkg::CFG_W-1:0] i_cfg_wdata
);

    ofs_pkg::t_ofs_cmd cmd;
    ofs_pkg::t_ofs_sts sts;

    ofs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ofs_dpath #(
        .MAX_FRAME   (MAX_FRAME),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample     (i_sample),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .o_frame_last (o_frame_last)
    );

endmodule

// ----- rtl/ofs_ram.sv -----
// ofs_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module ofs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ofs_ctrl.sv -----
// ofs_ctrl: controller state machine, accepts input beats and sequences frame read-out
// depends on ofs_pkg
module ofs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_mode,
    input  ofs_pkg::t_ofs_sts i_sts,
    output logic              o_in_stall,
    output ofs_pkg::t_ofs_cmd o_cmd
);

    ofs_pkg::t_ofs_state r_state;
    ofs_pkg::t_ofs_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ofs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ofs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == ofs_pkg::MODE_FLUSH) begin
                        o_cmd.flush = 1'b1;
                    end else begin
                        o_cmd.write = 1'b1;
                        if (i_sts.frame_due) begin
                            o_cmd.start = 1'b1;
                            n_state     = ofs_pkg::ST_EMIT;
                        end
                    end
                end
            end
            ofs_pkg::ST_EMIT: begin
                o_in_stall  = 1'b1;
                o_cmd.issue = i_sts.out_free;
                if (i_sts.out_free && i_sts.last_rd) begin
                    n_state = ofs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ofs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/ofs_dpath.sv -----
// ofs_dpath: config registers, frame counter, ring pointers and output beat register
// depends on ofs_pkg and ofs_ram
module ofs_dpath #(
    parameter int MAX_FRAME   = ofs_pkg::MAX_FRAME_DEF,
    parameter int SAMPLE_BITS = ofs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ofs_pkg::t_ofs_cmd             i_cmd,
    output ofs_pkg::t_ofs_sts             o_sts,
    input  logic                          i_cfg_we,
    input  logic [ofs_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [ofs_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [SAMPLE_BITS-1:0]        o_sample_out,
    output logic                          o_frame_last
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int CW = ((AW > ofs_pkg::FS_W) ? AW : ofs_pkg::FS_W) + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_FRAME - 1);

    logic [ofs_pkg::FS_W-1:0]    r_frame_size;
    logic [ofs_pkg::OV_W-1:0]    r_overlap;
    logic [ofs_pkg::UNTIL_W-1:0] r_until;
    logic [ofs_pkg::UNTIL_W-1:0] n_until;
    logic [AW-1:0]               r_wslot;
    logic [AW-1:0]               n_wslot;
    logic [AW-1:0]               r_rd_slot;
    logic [AW-1:0]               n_rd_slot;
    logic [ofs_pkg::FS_W-1:0]    r_rd_left;
    logic [ofs_pkg::FS_W-1:0]    n_rd_left;
    logic                        r_out_valid;
    logic                        r_last;

    logic [ofs_pkg::FS_W-1:0]    fs_eff;
    logic [ofs_pkg::FS_W-1:0]    cfg_fs;
    logic signed [11:0]          fs_s;
    logic signed [11:0]          ov_s;
    logic signed [11:0]          diff_s;
    logic [ofs_pkg::UNTIL_W-1:0] stride;
    logic [CW-1:0]               wsa_x;
    logic [CW-1:0]               fs_x;
    logic [CW-1:0]               start_x;

    assign fs_eff = ofs_pkg::eff_fs(r_frame_size, MAX_FRAME);
    assign cfg_fs = (i_cfg_index == ofs_pkg::CFG_FRAME_SIZE) ?
                    i_cfg_wdata[ofs_pkg::FS_W-1:0] : r_frame_size;

    // stride = frame size minus overlap, at least one
    assign fs_s   = signed'({5'b0, fs_eff});
    assign ov_s   = signed'({r_overlap[ofs_pkg::OV_W-1], r_overlap});
    assign diff_s = fs_s - ov_s;
    assign stride = (ov_s >= fs_s) ? ofs_pkg::UNTIL_W'(1) : diff_s[ofs_pkg::UNTIL_W-1:0];

    assign n_wslot = (r_wslot == LAST_SLOT) ? '0 : r_wslot + AW'(1);

    // oldest slot of the frame that ends with the sample being written
    assign wsa_x   = CW'(n_wslot);
    assign fs_x    = CW'(fs_eff);
    assign start_x = (wsa_x >= fs_x) ? (wsa_x - fs_x) : (wsa_x + CW'(MAX_FRAME) - fs_x);

    always_comb begin
        n_until = r_until;
        if (i_cfg_we) begin
            n_until = ofs_pkg::UNTIL_W'(ofs_pkg::eff_fs(cfg_fs, MAX_FRAME));
        end else if (i_cmd.flush) begin
            n_until = ofs_pkg::UNTIL_W'(fs_eff);
        end else if (i_cmd.write) begin
            n_until = (r_until == ofs_pkg::UNTIL_W'(1)) ? stride : r_until - ofs_pkg::UNTIL_W'(1);
        end
    end

    always_comb begin
        n_rd_slot = r_rd_slot;
        n_rd_left = r_rd_left;
        if (i_cmd.start) begin
            n_rd_slot = start_x[AW-1:0];
            n_rd_left = fs_eff;
        end else if (i_cmd.issue) begin
            n_rd_slot = (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + AW'(1);
            n_rd_left = r_rd_left - ofs_pkg::FS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= ofs_pkg::FS_RESET;
            r_overlap    <= ofs_pkg::OV_RESET;
            r_until      <= ofs_pkg::UNTIL_W'(ofs_pkg::eff_fs(ofs_pkg::FS_RESET, MAX_FRAME));
            r_wslot      <= '0;
            r_rd_slot    <= '0;
            r_rd_left    <= '0;
            r_out_valid  <= 1'b0;
            r_last       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ofs_pkg::CFG_FRAME_SIZE: r_frame_size <= i_cfg_wdata[ofs_pkg::FS_W-1:0];
                    ofs_pkg::CFG_OVERLAP:    r_overlap    <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r_until   <= n_until;
            r_rd_slot <= n_rd_slot;
            r_rd_left <= n_rd_left;
            if (i_cmd.write) begin
                r_wslot <= n_wslot;
            end
            if (i_cmd.issue) begin
                r_out_valid <= 1'b1;
                r_last      <= o_sts.last_rd;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    ofs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_FRAME)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_wslot),
        .i_wdata (i_sample),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_slot),
        .o_rdata (o_sample_out)
    );

    assign o_sts.frame_due = (r_until == ofs_pkg::UNTIL_W'(1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.last_rd   = (r_rd_left == ofs_pkg::FS_W'(1));

    assign o_out_valid  = r_out_valid;
    assign o_frame_last = r_last;

    a_until_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_until != '0)
        else $error("frame counter reached zero");

    a_issue_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> r_rd_left != '0)
        else $error("read issued with no samples left in frame");

    a_issue_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> (!r_out_valid || !i_out_stall))
        else $error("read issued over a stalled beat");

    a_start_loads_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_rd_left != '0) && (r_rd_slot <= LAST_SLOT) && !i_cmd.write)
        else $error("frame start left a bad read state");

endmodule
